>>> src/snp_cwd_pkg.sv
// ----------------------------------------------------------------------------
// snp_cwd_pkg
// Shared widths, codes and a saturating helper for the SNP cluster window
// detector.
// ----------------------------------------------------------------------------
package snp_cwd_pkg;

	localparam int POS_W     = 24;
	localparam int CNT_W     = 24;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_CUTOFF = CFG_IDX_W'(1);

	// reset values of the configuration registers
	localparam logic [CFG_W-1:0] WINDOW_SIZE_RST    = CFG_W'(100);
	localparam logic [CFG_W-1:0] CLUSTER_CUTOFF_RST = CFG_W'(5);

	// record kinds
	localparam logic REC_CLUSTER = 1'b0;
	localparam logic REC_TOTALS  = 1'b1;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CFG_W-1:0] cfg_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// saturating a + b on count values
	function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

>>> src/snp_cwd_item_if.sv
// ----------------------------------------------------------------------------
// snp_cwd_item_if
// Input item channel: one mutation position and the end-of-sequence mark.
// ----------------------------------------------------------------------------
interface snp_cwd_item_if;
	import snp_cwd_pkg::*;

	logic valid;
	logic ready;
	pos_t position;
	logic last_item;

	modport source (output valid, output position, output last_item, input ready);
	modport sink   (input valid, input position, input last_item, output ready);
endinterface

>>> src/snp_cwd_rec_if.sv
// ----------------------------------------------------------------------------
// snp_cwd_rec_if
// Result item channel: closed cluster records and final totals records.
// ----------------------------------------------------------------------------
interface snp_cwd_rec_if;
	import snp_cwd_pkg::*;

	logic valid;
	logic ready;
	logic record_kind;
	pos_t cluster_start;
	pos_t cluster_end;
	cnt_t snp_count;
	cnt_t total_clusters;
	cnt_t total_snps;
	logic last_of_run;

	modport source (
		output valid, output record_kind, output cluster_start, output cluster_end,
		output snp_count, output total_clusters, output total_snps,
		output last_of_run, input ready
	);
	modport sink (
		input valid, input record_kind, input cluster_start, input cluster_end,
		input snp_count, input total_clusters, input total_snps,
		input last_of_run, output ready
	);
endinterface

>>> src/snp_cwd_cfg_if.sv
// ----------------------------------------------------------------------------
// snp_cwd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface snp_cwd_cfg_if;
	import snp_cwd_pkg::*;

	logic     valid;
	logic     ready;
	cfg_idx_t index;
	cfg_t     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/snp_cluster_window_detector_core.sv
// ----------------------------------------------------------------------------
// snp_cluster_window_detector_core
// Sliding window of recent mutation positions held in a ring memory; opens,
// extends and closes clusters and reports closed clusters and final totals.
// ----------------------------------------------------------------------------
// Sequence: accept in S_IDLE; S_CHECK drops the P stale entries from the
//   window front, one ring read per cycle; S_EMIT loads the R results (0 to 3)
//   one at a time into the output register, waiting while it is held.
// No new item is taken until the last result is loaded; the ring memory's
//   single registered read port sets the check loop.
// Reset: control state, counters and config registers reset at once; the
//   ring memory has no clearing pass and is read only where written.
module snp_cluster_window_detector_core #(
	parameter int WINDOW_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	snp_cwd_item_if.sink       items,
	snp_cwd_rec_if.source      records,
	snp_cwd_cfg_if.sink        cfg
);
	import snp_cwd_pkg::*;

	localparam int HW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int SW = HW + 1;

	localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_DEPTH);
	localparam logic [HW-1:0] HEAD_LAST = HW'(WINDOW_DEPTH - 1);

	// sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_EMIT  = 2'd2;

	logic [1:0]    state_q;

	// configuration
	cfg_t          window_size_q;
	cfg_t          cluster_cutoff_q;

	// window ring
	pos_t          ring_mem [WINDOW_DEPTH];
	pos_t          rd_q;
	logic [HW-1:0] rd_addr;
	logic [HW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic          fwd_q;

	// current item
	pos_t          pos_q;
	logic          last_q;

	// cluster state
	logic          open_q;
	pos_t          open_start_q;
	pos_t          open_end_q;
	cnt_t          open_count_q;
	logic          prev_joined_q;
	cnt_t          cluster_total_q;
	cnt_t          snp_total_q;

	// pending results
	logic          pend_close_q;
	logic          pend_flush_q;
	logic          pend_tot_q;
	pos_t          close_start_q;
	pos_t          close_end_q;
	cnt_t          close_count_q;

	// output register
	logic          out_valid_q;
	logic          out_kind_q;
	pos_t          out_start_q;
	pos_t          out_end_q;
	cnt_t          out_count_q;
	cnt_t          out_tclu_q;
	cnt_t          out_tsnp_q;
	logic          out_last_q;

	logic          in_fire;
	logic          out_free;
	logic [HW-1:0] head_push;
	logic [FW-1:0] fill_base;
	logic [SW-1:0] tail_sum;
	logic [HW-1:0] tail_addr;
	logic [HW-1:0] head_inc;
	pos_t          head_val;
	logic          pop;
	logic          join_w;
	logic          extend;
	logic          load_tot;

	function automatic logic [HW-1:0] ring_inc(input logic [HW-1:0] a);
		return (a == HEAD_LAST) ? '0 : a + HW'(1);
	endfunction

	assign items.ready = (state_q == S_IDLE);
	assign in_fire     = items.valid && items.ready;
	assign cfg.ready   = 1'b1;
	assign out_free    = !out_valid_q || records.ready;

	// push: drop the oldest entry when the ring is full, then append at the tail
	always_comb begin
		if (fill_q == FILL_FULL) begin
			head_push = ring_inc(head_q);
			fill_base = FW'(WINDOW_DEPTH - 1);
		end else begin
			head_push = head_q;
			fill_base = fill_q;
		end
		tail_sum = SW'(head_push) + SW'(fill_base);
		if (tail_sum >= SW'(WINDOW_DEPTH))
			tail_addr = HW'(tail_sum - SW'(WINDOW_DEPTH));
		else
			tail_addr = tail_sum[HW-1:0];
	end

	assign head_inc = ring_inc(head_q);
	assign rd_addr  = (state_q == S_IDLE) ? head_push : head_inc;

	// front entry; the entry just written bypasses the memory when it is the head
	assign head_val = fwd_q ? pos_q : rd_q;
	assign pop      = (25'(head_val) + 25'(window_size_q)) < 25'(pos_q);
	assign join_w   = 32'(fill_q) > 32'(cluster_cutoff_q);
	assign extend   = open_q && (fill_q > FW'(1)) && prev_joined_q;
	assign load_tot = (state_q == S_EMIT) && out_free && !pend_close_q
		&& !pend_flush_q && pend_tot_q;

	// ring memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (in_fire)
			ring_mem[tail_addr] <= items.position;
		rd_q <= ring_mem[rd_addr];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q    <= WINDOW_SIZE_RST;
			cluster_cutoff_q <= CLUSTER_CUTOFF_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_WINDOW_SIZE:    window_size_q    <= cfg.data;
				CFG_CLUSTER_CUTOFF: cluster_cutoff_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer, window and cluster state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			head_q          <= '0;
			fill_q          <= '0;
			fwd_q           <= 1'b0;
			pos_q           <= '0;
			last_q          <= 1'b0;
			open_q          <= 1'b0;
			open_start_q    <= '0;
			open_end_q      <= '0;
			open_count_q    <= '0;
			prev_joined_q   <= 1'b0;
			cluster_total_q <= '0;
			snp_total_q     <= '0;
			pend_close_q    <= 1'b0;
			pend_flush_q    <= 1'b0;
			pend_tot_q      <= 1'b0;
			close_start_q   <= '0;
			close_end_q     <= '0;
			close_count_q   <= '0;
			out_valid_q     <= 1'b0;
			out_kind_q      <= REC_CLUSTER;
			out_start_q     <= '0;
			out_end_q       <= '0;
			out_count_q     <= '0;
			out_tclu_q      <= '0;
			out_tsnp_q      <= '0;
			out_last_q      <= 1'b0;
		end else begin
			// in S_EMIT a taken item is always replaced by the next one
			if (records.ready && (state_q != S_EMIT))
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						head_q  <= head_push;
						fill_q  <= fill_base + FW'(1);
						fwd_q   <= (fill_base == '0);
						pos_q   <= items.position;
						last_q  <= items.last_item;
						state_q <= S_CHECK;
					end
				end

				S_CHECK: begin
					if (pop) begin
						// drop the stale front entry and fetch the next one
						head_q <= head_inc;
						fill_q <= fill_q - FW'(1);
						fwd_q  <= 1'b0;
					end else begin
						prev_joined_q <= join_w;
						if (join_w && extend) begin
							open_end_q   <= pos_q;
							open_count_q <= sat_add(open_count_q, cnt_t'(1));
							snp_total_q  <= sat_add(snp_total_q, cnt_t'(1));
						end else if (join_w) begin
							// new cluster over the whole window; close the old one if one is open
							pend_close_q    <= open_q;
							close_start_q   <= open_start_q;
							close_end_q     <= open_end_q;
							close_count_q   <= open_count_q;
							open_q          <= 1'b1;
							open_start_q    <= head_val;
							open_end_q      <= pos_q;
							open_count_q    <= CNT_W'(fill_q);
							cluster_total_q <= sat_add(cluster_total_q, cnt_t'(1));
							snp_total_q     <= sat_add(snp_total_q, CNT_W'(fill_q));
						end
						if (last_q) begin
							pend_flush_q <= open_q || join_w;
							pend_tot_q   <= 1'b1;
						end
						if (last_q || (join_w && !extend && open_q))
							state_q <= S_EMIT;
						else
							state_q <= S_IDLE;
					end
				end

				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						priority if (pend_close_q) begin
							out_kind_q   <= REC_CLUSTER;
							out_start_q  <= close_start_q;
							out_end_q    <= close_end_q;
							out_count_q  <= close_count_q;
							out_tclu_q   <= '0;
							out_tsnp_q   <= '0;
							out_last_q   <= !pend_flush_q && !pend_tot_q;
							pend_close_q <= 1'b0;
							if (!pend_flush_q && !pend_tot_q)
								state_q <= S_IDLE;
						end else if (pend_flush_q) begin
							out_kind_q   <= REC_CLUSTER;
							out_start_q  <= open_start_q;
							out_end_q    <= open_end_q;
							out_count_q  <= open_count_q;
							out_tclu_q   <= '0;
							out_tsnp_q   <= '0;
							out_last_q   <= !pend_tot_q;
							pend_flush_q <= 1'b0;
							if (!pend_tot_q)
								state_q <= S_IDLE;
						end else begin
							// totals, then the stream state returns to reset
							out_kind_q      <= REC_TOTALS;
							out_start_q     <= '0;
							out_end_q       <= '0;
							out_count_q     <= '0;
							out_tclu_q      <= cluster_total_q;
							out_tsnp_q      <= snp_total_q;
							out_last_q      <= 1'b1;
							pend_tot_q      <= 1'b0;
							head_q          <= '0;
							fill_q          <= '0;
							open_q          <= 1'b0;
							open_start_q    <= '0;
							open_end_q      <= '0;
							open_count_q    <= '0;
							prev_joined_q   <= 1'b0;
							cluster_total_q <= '0;
							snp_total_q     <= '0;
							state_q         <= S_IDLE;
						end
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign records.valid          = out_valid_q;
	assign records.record_kind    = out_kind_q;
	assign records.cluster_start  = out_start_q;
	assign records.cluster_end    = out_end_q;
	assign records.snp_count      = out_count_q;
	assign records.total_clusters = out_tclu_q;
	assign records.total_snps     = out_tsnp_q;
	assign records.last_of_run    = out_last_q;

	// no item is taken while results of the previous one are still pending
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(pend_close_q || pend_flush_q || pend_tot_q))
		else $error("item accepted with results pending");

	// the current position is always in the window while checking
	a_check_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (fill_q != '0) && (fill_q <= FILL_FULL))
		else $error("window empty or overfull during check");

	// a totals record leaves the stream state cleared
	a_tot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load_tot |=> (fill_q == '0) && !open_q && (cluster_total_q == '0)
			&& out_valid_q && (out_kind_q == REC_TOTALS) && out_last_q)
		else $error("stream state not cleared after totals");

	// a flush record is always followed by a totals record
	a_flush_then_tot: assert property (@(posedge clk) disable iff (!arst_n)
		pend_flush_q |-> pend_tot_q)
		else $error("flush pending without totals");

	// the front pointer stays inside the ring
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) && pop |=> (head_q <= HEAD_LAST) && (state_q == S_CHECK))
		else $error("front pointer out of range");

endmodule
